// ===== design/seir_pkg.sv =====
// Shared types and constants for the LIFO stack engine with invert and rotate.
package seir_pkg;

  // Stack geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 11;
  localparam int WORD_W   = 32;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INVERT = 2'd2,
    OP_ROTATE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADDEPTH = 2'd3
  } stat_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [WORD_W-1:0] push_value;
    logic [CNT_W-1:0]         rotate_depth;
  } in_item_t;

  typedef struct packed {
    stat_t                    status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [WORD_W-1:0] top_word;
  } out_item_t;

  // Datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP       = 4'd0,
    DP_SET_STAT  = 4'd1,
    DP_PUSH      = 4'd2,
    DP_POP       = 4'd3,
    DP_POP_TOP   = 4'd4,
    DP_INV_INIT  = 4'd5,
    DP_INV_RHI   = 4'd6,
    DP_INV_WLO   = 4'd7,
    DP_INV_WHI   = 4'd8,
    DP_ROT_INIT  = 4'd9,
    DP_ROT_MOVE  = 4'd10,
    DP_ROT_SHIFT = 4'd11,
    DP_ROT_LAST  = 4'd12
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
    stat_t  stat;
    logic   out_ld;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic depth_bad;
    logic few;
    logic inv_more;
    logic rot_one;
    logic rot_end;
  } dp_stat_t;

endpackage

// ===== design/seir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module seir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/seir_ctrl.sv =====
// Controller state machine: sequences one transaction at a time through the datapath.
module seir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  seir_pkg::dp_stat_t st,
  output seir_pkg::dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_POP_TOP   = 11'b000_0000_0010,
    S_INV_RHI   = 11'b000_0000_0100,
    S_INV_WLO   = 11'b000_0000_1000,
    S_INV_WHI   = 11'b000_0001_0000,
    S_ROT_MOVE  = 11'b000_0010_0000,
    S_ROT_SHIFT = 11'b000_0100_0000,
    S_ROT_LAST  = 11'b000_1000_0000,
    S_FIN       = 11'b001_0000_0000,
    S_SPARE_A   = 11'b010_0000_0000,
    S_SPARE_B   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt  = state_r;
    cmd.op     = seir_pkg::DP_NOP;
    cmd.stat   = seir_pkg::ST_DONE;
    cmd.out_ld = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (st.op)
            seir_pkg::OP_PUSH: begin
              state_nxt = S_FIN;
              if (st.full) begin
                cmd.op   = seir_pkg::DP_SET_STAT;
                cmd.stat = seir_pkg::ST_FULL;
              end else begin
                cmd.op = seir_pkg::DP_PUSH;
              end
            end
            seir_pkg::OP_POP: begin
              if (st.empty) begin
                cmd.op    = seir_pkg::DP_SET_STAT;
                cmd.stat  = seir_pkg::ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                cmd.op    = seir_pkg::DP_POP;
                state_nxt = S_POP_TOP;
              end
            end
            seir_pkg::OP_INVERT: begin
              if (st.few) begin
                cmd.op    = seir_pkg::DP_SET_STAT;
                state_nxt = S_FIN;
              end else begin
                cmd.op    = seir_pkg::DP_INV_INIT;
                state_nxt = S_INV_RHI;
              end
            end
            seir_pkg::OP_ROTATE: begin
              if (st.depth_bad) begin
                cmd.op    = seir_pkg::DP_SET_STAT;
                cmd.stat  = seir_pkg::ST_BADDEPTH;
                state_nxt = S_FIN;
              end else begin
                cmd.op    = seir_pkg::DP_ROT_INIT;
                state_nxt = S_ROT_MOVE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_TOP: begin
        cmd.op    = seir_pkg::DP_POP_TOP;
        state_nxt = S_FIN;
      end
      // Invert: one pair of entries swapped per pass of read high, write low, write high
      S_INV_RHI: begin
        cmd.op    = seir_pkg::DP_INV_RHI;
        state_nxt = S_INV_WLO;
      end
      S_INV_WLO: begin
        cmd.op    = seir_pkg::DP_INV_WLO;
        state_nxt = S_INV_WHI;
      end
      S_INV_WHI: begin
        cmd.op    = seir_pkg::DP_INV_WHI;
        state_nxt = st.inv_more ? S_INV_RHI : S_FIN;
      end
      // Rotate: capture the moved entry, shift one entry per cycle, drop it on top
      S_ROT_MOVE: begin
        cmd.op    = seir_pkg::DP_ROT_MOVE;
        state_nxt = st.rot_one ? S_ROT_LAST : S_ROT_SHIFT;
      end
      S_ROT_SHIFT: begin
        cmd.op = seir_pkg::DP_ROT_SHIFT;
        if (st.rot_end) begin
          state_nxt = S_ROT_LAST;
        end
      end
      S_ROT_LAST: begin
        cmd.op    = seir_pkg::DP_ROT_LAST;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Result register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken transaction");

  // An accepted transaction blocks the input until its result is out
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Output valid rises only from a load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_ld))
    else $error("output valid without a result load");

endmodule

// ===== design/seir_dp.sv =====
// Datapath: stack memory, fill level, top word, walk pointers and result register.
module seir_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  seir_pkg::in_item_t  in_data,
  input  seir_pkg::dp_cmd_t   cmd,
  output seir_pkg::dp_stat_t  st,
  output seir_pkg::out_item_t out_data
);

  seir_pkg::cnt_t      fill_r, fill_nxt;
  seir_pkg::word_t     top_r, top_nxt;
  seir_pkg::stat_t     stat_r, stat_nxt;
  seir_pkg::addr_t     ptr_a_r, ptr_a_nxt;   // lo pointer on invert, shift pointer on rotate
  seir_pkg::addr_t     ptr_b_r, ptr_b_nxt;   // hi pointer on invert
  seir_pkg::word_t     hold_r, hold_nxt;     // saved low entry / moved entry
  seir_pkg::out_item_t out_r;

  seir_pkg::cnt_t  fill_m1, fill_m2, base, depth;
  seir_pkg::cnt_t  ptr_a_ext, ptr_b_ext;
  logic            ram_we;
  seir_pkg::addr_t ram_waddr, ram_raddr;
  seir_pkg::word_t ram_wdata, ram_rdata;

  assign depth     = in_data.rotate_depth;
  assign fill_m1   = fill_r - seir_pkg::cnt_t'(1);
  assign fill_m2   = fill_r - seir_pkg::cnt_t'(2);
  assign base      = fill_r - depth;
  assign ptr_a_ext = seir_pkg::cnt_t'(ptr_a_r);
  assign ptr_b_ext = seir_pkg::cnt_t'(ptr_b_r);

  // Status toward the controller
  always_comb begin
    st.op        = in_data.operation;
    st.full      = (fill_r == seir_pkg::CAP_CNT);
    st.empty     = (fill_r == '0);
    st.depth_bad = (depth == '0) || (depth > fill_r);
    st.few       = (fill_r < seir_pkg::cnt_t'(2));
    st.inv_more  = ((ptr_a_ext + seir_pkg::cnt_t'(2)) < ptr_b_ext);
    st.rot_one   = ((ptr_a_ext + seir_pkg::cnt_t'(1)) == fill_r);
    st.rot_end   = ((ptr_a_ext + seir_pkg::cnt_t'(2)) == fill_r);
  end

  // Micro-operation decode
  always_comb begin
    fill_nxt  = fill_r;
    top_nxt   = top_r;
    stat_nxt  = stat_r;
    ptr_a_nxt = ptr_a_r;
    ptr_b_nxt = ptr_b_r;
    hold_nxt  = hold_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_a_r;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_a_r;
    unique case (cmd.op)
      seir_pkg::DP_NOP: ;
      seir_pkg::DP_SET_STAT: stat_nxt = cmd.stat;
      seir_pkg::DP_PUSH: begin
        stat_nxt  = cmd.stat;
        ram_we    = 1'b1;
        ram_waddr = seir_pkg::addr_t'(fill_r);
        ram_wdata = in_data.push_value;
        fill_nxt  = fill_r + seir_pkg::cnt_t'(1);
        top_nxt   = in_data.push_value;
      end
      seir_pkg::DP_POP: begin
        stat_nxt  = cmd.stat;
        fill_nxt  = fill_m1;
        ram_raddr = seir_pkg::addr_t'(fill_m2);
      end
      seir_pkg::DP_POP_TOP: top_nxt = ram_rdata;
      seir_pkg::DP_INV_INIT: begin
        stat_nxt  = cmd.stat;
        ptr_a_nxt = '0;
        ptr_b_nxt = seir_pkg::addr_t'(fill_m1);
        ram_raddr = '0;
      end
      seir_pkg::DP_INV_RHI: begin
        hold_nxt  = ram_rdata;
        ram_raddr = ptr_b_r;
      end
      seir_pkg::DP_INV_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_a_r;
        ram_wdata = ram_rdata;
      end
      seir_pkg::DP_INV_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_b_r;
        ram_wdata = hold_r;
        if (ptr_b_ext == fill_m1) begin
          top_nxt = hold_r;
        end
        ptr_a_nxt = seir_pkg::addr_t'(ptr_a_r + 1'b1);
        ptr_b_nxt = seir_pkg::addr_t'(ptr_b_r - 1'b1);
        // prefetch the next low entry
        ram_raddr = seir_pkg::addr_t'(ptr_a_r + 1'b1);
      end
      seir_pkg::DP_ROT_INIT: begin
        stat_nxt  = cmd.stat;
        ptr_a_nxt = seir_pkg::addr_t'(base);
        ram_raddr = seir_pkg::addr_t'(base);
      end
      seir_pkg::DP_ROT_MOVE: begin
        hold_nxt  = ram_rdata;
        ram_raddr = seir_pkg::addr_t'(ptr_a_r + 1'b1);
      end
      seir_pkg::DP_ROT_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_a_r;
        ram_wdata = ram_rdata;
        ptr_a_nxt = seir_pkg::addr_t'(ptr_a_r + 1'b1);
        ram_raddr = seir_pkg::addr_t'(ptr_a_r + 2'd2);
      end
      seir_pkg::DP_ROT_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = seir_pkg::addr_t'(fill_m1);
        ram_wdata = hold_r;
        top_nxt   = hold_r;
      end
      default: ;
    endcase
  end

  // Fill level is control state; the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    stat_r  <= stat_nxt;
    ptr_a_r <= ptr_a_nxt;
    ptr_b_r <= ptr_b_nxt;
    hold_r  <= hold_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r.status      <= stat_r;
      out_r.entry_count <= fill_r;
      out_r.top_word    <= (fill_r == '0) ? '0 : top_r;
    end
  end

  assign out_data = out_r;

  // Stack storage
  seir_ram #(
    .WIDTH (seir_pkg::WORD_W),
    .DEPTH (seir_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Fill level never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= seir_pkg::CAP_CNT)
    else $error("fill level above capacity");

  // A push grows the stack by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == seir_pkg::DP_PUSH) |=> (fill_r == $past(fill_r) + seir_pkg::cnt_t'(1)))
    else $error("push did not advance the fill level");

  // Invert and rotate writes stay inside the held entries
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (cmd.op != seir_pkg::DP_PUSH)) |-> (seir_pkg::cnt_t'(ram_waddr) < fill_r))
    else $error("reorder write outside the held entries");

endmodule

// ===== design/stack_engine_invert_rotate.sv =====
// Top level of the LIFO stack engine with invert and rotate.
//
//   channel   direction  handshake              payload
//   in_*      input      in_valid / in_ready    in_data   (seir_pkg::in_item_t)
//   out_*     output     out_valid / out_ready  out_data  (seir_pkg::out_item_t)
//
// One transaction is processed at a time; each gives one result.
// Push, rejected push, empty pop, bad rotate and invert of under two entries go
// straight to the result load; pop first reads the new top back from stack memory.
// Invert swaps pairs from both ends; rotate moves the entry at depth d to the top.
// Both walks are paced by the single read and single write port of the stack memory.
// Synchronous active-low reset empties the stack; no clearing pass is needed.
// A result waiting on out_ready holds the result register; the next transaction
// is accepted meanwhile and stalls only at its own result load.
module stack_engine_invert_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  seir_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output seir_pkg::out_item_t out_data
);

  seir_pkg::dp_cmd_t  cmd;
  seir_pkg::dp_stat_t st;

  seir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  seir_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule
